[rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int ECNT_W   = 5;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_ZERO_PRIO = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] entry_value;
    logic        [30:0] entry_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic               removed_valid;
    logic signed [31:0] head_value;
    logic        [30:0] head_priority;
    logic [ECNT_W-1:0]  entry_count;
    logic               is_empty;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic        [30:0] prio;
    logic signed [31:0] value;
  } slot_t;

endpackage

`default_nettype wire

[rtl/spq_cmp.sv]
`default_nettype none

module spq_cmp (
  input  spq_pkg::slot_t a_i,
  input  spq_pkg::slot_t b_i,
  output logic           before_o
);
  import spq_pkg::*;

  logic prio_lt;
  logic prio_eq;
  logic value_le;

  assign prio_lt  = a_i.prio < b_i.prio;
  assign prio_eq  = a_i.prio == b_i.prio;
  assign value_le = a_i.value <= b_i.value;
  assign before_o = prio_lt || (prio_eq && value_le);

endmodule

`default_nettype wire

[rtl/sorted_priority_queue_unit.sv]
`default_nettype none

// Channel | Direction | Handshake                   | Payload
// input   | in        | in_valid_i / in_ready_o     | in_item_i  (spq_pkg::in_item_t)
// output  | out       | out_valid_o / out_ready_i   | out_item_o (spq_pkg::out_item_t)
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Add: from the tail, entries the new one goes before move back; then it is written.
// Remove: returns the head and moves the rest forward; errors skip to the result.
// Each moved entry costs one read and one write of the slot memory; add checks it
// with the one shared comparator.
// Reset clears the count and control; slot memory is not cleared.
// A stalled result holds in the output register; the next result waits and blocks input.

module sorted_priority_queue_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_item_t out_item_o
);
  import spq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ADD_RD  = 6'b000010,
    S_ADD_CMP = 6'b000100,
    S_REM_RD  = 6'b001000,
    S_REM_WR  = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   km1;
  slot_t              new_q, new_d;
  slot_t              head_q, head_d;
  status_e            status_q, status_d;
  logic signed [31:0] rem_val_q, rem_val_d;
  logic               rem_vld_q, rem_vld_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  slot_t              slot_mem_q [CAPACITY];
  slot_t              rd_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_t              wr_data;
  logic               goes_first;

  spq_cmp u_cmp (
    .a_i      (new_q),
    .b_i      (rd_q),
    .before_o (goes_first)
  );

  assign km1 = k_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= slot_mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    new_d       = new_q;
    head_d      = head_q;
    status_d    = status_q;
    rem_val_d   = rem_val_q;
    rem_vld_d   = rem_vld_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = k_q[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = k_q[IDX_W-1:0];
    wr_data     = new_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          new_d.prio  = in_item_i.entry_priority;
          new_d.value = in_item_i.entry_value;
          status_d    = ST_OK;
          rem_val_d   = '0;
          rem_vld_d   = 1'b0;
          if (in_item_i.op == OP_REMOVE) begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              rem_val_d = head_q.value;
              rem_vld_d = 1'b1;
              k_d       = CNT_W'(1);
              state_d   = S_REM_RD;
            end
          end else if (in_item_i.entry_priority == '0) begin
            status_d = ST_ZERO_PRIO;
            state_d  = S_DONE;
          end else if (cnt_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            k_d     = cnt_q;
            state_d = S_ADD_RD;
          end
        end
      end
      S_ADD_RD: begin
        if (k_q == '0) begin
          wr_en   = 1'b1;
          head_d  = new_q;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = km1[IDX_W-1:0];
          state_d = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        wr_en = 1'b1;
        if (goes_first) begin
          wr_data = rd_q;
          k_d     = km1;
          state_d = S_ADD_RD;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_REM_RD: begin
        if (k_q == cnt_q) begin
          cnt_d   = km1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          state_d = S_REM_WR;
        end
      end
      S_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = km1[IDX_W-1:0];
        wr_data = rd_q;
        if (k_q == CNT_W'(1)) begin
          head_d = rd_q;
        end
        k_d     = k_q + CNT_W'(1);
        state_d = S_REM_RD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.removed_value = rem_val_q;
          out_d.removed_valid = rem_vld_q;
          out_d.head_value    = (cnt_q == '0) ? '0 : head_q.value;
          out_d.head_priority = (cnt_q == '0) ? '0 : head_q.prio;
          out_d.entry_count   = ECNT_W'(cnt_q);
          out_d.is_empty      = (cnt_q == '0);
          out_d.status        = status_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    new_q     <= new_d;
    head_q    <= head_d;
    status_q  <= status_d;
    rem_val_q <= rem_val_d;
    rem_vld_q <= rem_vld_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[rtl/spq_chk.sv]
`default_nettype none

module spq_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input spq_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input spq_pkg::out_item_t out_item_o
);
  import spq_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.removed_valid |-> out_item_o.status == ST_OK)
    else $error("removed_valid on a failed step");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.is_empty == (out_item_o.entry_count == '0))
    else $error("is_empty disagrees with entry_count");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |->
      out_item_o.head_value == '0 && out_item_o.head_priority == '0)
    else $error("empty queue shows a head");

  // a transfer in, with no result pending, is not answered in the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without sequencing");

endmodule

bind sorted_priority_queue_unit spq_chk u_spq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
